// ===== sv/gtz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtz_pkg
// Shared types and constants of the three-tone Goertzel detector.
// ----------------------------------------------------------------------------
package gtz_pkg;

    localparam int WINDOW_DEPTH_DEF    = 512;
    localparam int COEFF_FRAC_BITS_DEF = 14;

    localparam int WIN_FRAC_BITS = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;

    // Divider operand widths: |re| needs 49 bits, scale*span needs 27+17 bits
    localparam int DIV_NUM_W = 49;
    localparam int DIV_DEN_W = 44;
    localparam int DIV_CNT_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_ONE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_TWO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_THREE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CORR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LEN   = 3'd5;

    typedef enum logic [1:0] {
        KIND_SAMPLE,
        KIND_WIN_WRITE,
        KIND_DROP
    } gtz_kind_e;

    typedef struct packed {
        gtz_kind_e          kind;
        logic signed [15:0] sample;
        logic [8:0]         index;
        logic signed [15:0] value;
    } gtz_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_ACC,
        ST_FDIV,
        ST_FC,
        ST_FS,
        ST_FI,
        ST_DRE,
        ST_DIM,
        ST_SQ,
        ST_SUM,
        ST_OUT
    } gtz_state_e;

endpackage

// ===== sv/gtz_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtz_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gtz_front #(
    parameter int WINDOW_DEPTH = gtz_pkg::WINDOW_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_sample,
    input  logic [8:0]         s_window_index,
    input  logic signed [15:0] s_window_value,
    output logic               item_valid,
    output gtz_pkg::gtz_item_t item,
    input  logic               item_pop
);

    gtz_pkg::gtz_item_t q_mem [2];
    logic [1:0]         count_reg, count_next;
    logic               wr_ptr_reg, rd_ptr_reg;
    logic               push;
    gtz_pkg::gtz_item_t new_item;

    always_comb begin
        new_item.sample = s_sample;
        new_item.index  = s_window_index;
        new_item.value  = s_window_value;
        if (!s_command) begin
            new_item.kind = gtz_pkg::KIND_SAMPLE;
        end else if (32'(s_window_index) < WINDOW_DEPTH) begin
            new_item.kind = gtz_pkg::KIND_WIN_WRITE;
        end else begin
            new_item.kind = gtz_pkg::KIND_DROP;
        end
    end

    assign s_ready    = (count_reg != 2'd2);
    assign push       = s_valid && s_ready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !item_pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && item_pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (item_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

// ===== sv/gtz_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtz_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtz_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gtz_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [gtz_pkg::DIV_DEN_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [gtz_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int NW = gtz_pkg::DIV_NUM_W;
    localparam int DW = gtz_pkg::DIV_DEN_W;

    logic [NW-1:0]                  num_reg;
    logic [DW-1:0]                  rem_reg, den_reg;
    logic [gtz_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           busy_reg, done_reg;
    logic [DW:0]                    trial, diff;
    logic                           take;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NW-2:0], take};
            rem_reg <= take ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gtz_pkg::DIV_CNT_W'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== sv/gtz_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtz_back
// Window table, Goertzel recurrences, block-end scaling and result register.
// ----------------------------------------------------------------------------
module gtz_back #(
    parameter int WINDOW_DEPTH    = gtz_pkg::WINDOW_DEPTH_DEF,
    parameter int COEFF_FRAC_BITS = gtz_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gtz_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtz_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           item_valid,
    input  gtz_pkg::gtz_item_t             item,
    output logic                           item_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_mag_one,
    output logic [31:0]                    m_mag_two,
    output logic [31:0]                    m_mag_three,
    output logic                           m_zero_span
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int LW = (CW > 10) ? CW : 10;
    localparam int NW = gtz_pkg::DIV_NUM_W;
    localparam int DW = gtz_pkg::DIV_DEN_W;
    localparam int WIN_FRAC_MSB = gtz_pkg::WIN_FRAC_BITS + 16;
    localparam logic signed [49:0] SAT_HI = 50'sh0_7FFF_FFFF;
    localparam logic signed [49:0] SAT_LO = -SAT_HI - 50'sd1;

    // configuration
    logic [47:0] tone_reg [3];
    logic [19:0] corr_reg;
    logic [9:0]  blen_reg;
    logic [7:0]  chunk_reg;
    logic [26:0] scale_reg;

    // engine state
    gtz_pkg::gtz_state_e state_reg, state_next;
    logic [1:0]          tk_reg;
    logic [LW-1:0]       count_reg;
    logic signed [15:0]  min_reg, max_reg, s_reg;
    logic signed [31:0]  q1_reg [3];
    logic signed [31:0]  q2_reg [3];
    logic signed [16:0]  x_reg;
    logic signed [47:0]  prod_reg;
    logic [NW-1:0]       num_re_reg, num_im_reg, qa_reg, qb_reg;
    logic [DW-1:0]       den_reg;
    logic [31:0]         sa_reg, sb_reg;
    logic                sat_reg, zero_reg;
    logic [31:0]         mag_work [3];

    // window memory
    logic signed [15:0]  win_mem [WINDOW_DEPTH];
    logic signed [15:0]  win_rdata_reg;
    logic                win_we;

    // output register
    logic                out_valid_reg;
    logic [31:0]         out_mag_reg [3];
    logic                out_zero_reg;

    // combinational
    logic [LW-1:0]       len_eff, blen_ext;
    logic                block_end;
    logic signed [15:0]  coeff_sel, cos_sel, sin_sel, coeff_nxt;
    logic signed [31:0]  sw_prod;
    logic signed [49:0]  acc;
    logic signed [31:0]  q0_sat;
    logic signed [48:0]  re_val, im_val;
    logic [16:0]         span;
    logic                zero_now;
    logic [32:0]         sum33;
    logic                div_start, div_busy, div_done;
    logic [NW-1:0]       div_dividend, div_quot;
    logic                out_load;

    function automatic logic [47:0] tone_pick(input logic [47:0] t0, input logic [47:0] t1,
                                              input logic [47:0] t2, input logic [1:0] k);
        logic [47:0] r;
        case (k)
            2'd0:    r = t0;
            2'd1:    r = t1;
            2'd2:    r = t2;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [NW-1:0] abs49(input logic signed [48:0] v);
        return v[48] ? NW'(-v) : NW'(v);
    endfunction

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_reg[0] <= '0;
            tone_reg[1] <= '0;
            tone_reg[2] <= '0;
            corr_reg    <= 20'd1;
            blen_reg    <= 10'd512;
            chunk_reg   <= 8'd2;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gtz_pkg::CFG_TONE_ONE:    tone_reg[0] <= cfg_data;
                gtz_pkg::CFG_TONE_TWO:    tone_reg[1] <= cfg_data;
                gtz_pkg::CFG_TONE_THREE:  tone_reg[2] <= cfg_data;
                gtz_pkg::CFG_WINDOW_CORR: corr_reg    <= cfg_data[19:0];
                gtz_pkg::CFG_BLOCK_LEN:   blen_reg    <= cfg_data[9:0];
                gtz_pkg::CFG_CHUNK_LEN:   chunk_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        scale_reg <= 27'(chunk_reg[7:1] * corr_reg);
    end

    always_comb begin
        blen_ext = LW'(blen_reg);
        if (blen_ext == '0) begin
            len_eff = LW'(1);
        end else if (blen_ext > LW'(WINDOW_DEPTH)) begin
            len_eff = LW'(WINDOW_DEPTH);
        end else begin
            len_eff = blen_ext;
        end
    end

    assign block_end = ((count_reg + LW'(1)) >= len_eff);

    // ---------------- window table ----------------
    assign win_we = item_pop && (item.kind == gtz_pkg::KIND_WIN_WRITE);

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[AW'(item.index)] <= item.value;
        end
        win_rdata_reg <= win_mem[count_reg[AW-1:0]];
    end

    // ---------------- arithmetic ----------------
    always_comb begin
        logic [47:0] tp, tn;
        tp        = tone_pick(tone_reg[0], tone_reg[1], tone_reg[2], tk_reg);
        tn        = tone_pick(tone_reg[0], tone_reg[1], tone_reg[2], tk_reg + 2'd1);
        coeff_sel = tp[47:32];
        cos_sel   = tp[31:16];
        sin_sel   = tp[15:0];
        coeff_nxt = tn[47:32];
    end

    assign sw_prod = s_reg * win_rdata_reg;
    assign acc     = 50'(prod_reg >>> COEFF_FRAC_BITS) - 50'(q2_reg[0]) + 50'(x_reg);

    always_comb begin
        if (acc > SAT_HI) begin
            q0_sat = 32'sh7FFF_FFFF;
        end else if (acc < SAT_LO) begin
            q0_sat = 32'sh8000_0000;
        end else begin
            q0_sat = acc[31:0];
        end
    end

    assign re_val   = 49'(prod_reg >>> COEFF_FRAC_BITS) - 49'(q2_reg[0]);
    assign im_val   = 49'(prod_reg >>> COEFF_FRAC_BITS);
    // min <= 0 <= max always, so the span is never negative
    assign span     = 17'(max_reg) - 17'(min_reg);
    assign zero_now = (scale_reg == '0) || (span == '0);
    assign sum33    = {1'b0, sa_reg} + {1'b0, sb_reg};

    // ---------------- divider ----------------
    assign div_dividend = (state_reg == gtz_pkg::ST_FI) ? num_re_reg : num_im_reg;

    gtz_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gtz_pkg::ST_IDLE: begin
                if (item_valid && item.kind == gtz_pkg::KIND_SAMPLE) begin
                    state_next = gtz_pkg::ST_MULX;
                end
            end
            gtz_pkg::ST_MULX: state_next = gtz_pkg::ST_ACC;
            gtz_pkg::ST_ACC: begin
                if (tk_reg == 2'd2) begin
                    state_next = block_end ? gtz_pkg::ST_FDIV : gtz_pkg::ST_IDLE;
                end
            end
            gtz_pkg::ST_FDIV: state_next = zero_now ? gtz_pkg::ST_OUT : gtz_pkg::ST_FC;
            gtz_pkg::ST_FC:   state_next = gtz_pkg::ST_FS;
            gtz_pkg::ST_FS:   state_next = gtz_pkg::ST_FI;
            gtz_pkg::ST_FI:   state_next = gtz_pkg::ST_DRE;
            gtz_pkg::ST_DRE: begin
                if (div_done) begin
                    state_next = gtz_pkg::ST_DIM;
                end
            end
            gtz_pkg::ST_DIM: begin
                if (div_done) begin
                    state_next = gtz_pkg::ST_SQ;
                end
            end
            gtz_pkg::ST_SQ:  state_next = gtz_pkg::ST_SUM;
            gtz_pkg::ST_SUM: state_next = (tk_reg == 2'd2) ? gtz_pkg::ST_OUT : gtz_pkg::ST_FC;
            gtz_pkg::ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = gtz_pkg::ST_IDLE;
                end
            end
            default: state_next = gtz_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        item_pop  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            gtz_pkg::ST_IDLE: item_pop  = item_valid;
            gtz_pkg::ST_FI:   div_start = 1'b1;
            gtz_pkg::ST_DRE:  div_start = div_done;
            gtz_pkg::ST_OUT:  out_load  = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gtz_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Tone history is kept in rotating registers: the tone being worked on is
    // always in slot 0, and three rotations restore the original order.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tk_reg    <= 2'd0;
            count_reg <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            q1_reg[0] <= '0;
            q1_reg[1] <= '0;
            q1_reg[2] <= '0;
            q2_reg[0] <= '0;
            q2_reg[1] <= '0;
            q2_reg[2] <= '0;
        end else begin
            case (state_reg)
                gtz_pkg::ST_IDLE: begin
                    if (item_pop && item.kind == gtz_pkg::KIND_SAMPLE) begin
                        s_reg <= item.sample;
                        if (item.sample < min_reg) begin
                            min_reg <= item.sample;
                        end
                        if (item.sample > max_reg) begin
                            max_reg <= item.sample;
                        end
                    end
                end
                gtz_pkg::ST_MULX: begin
                    x_reg    <= sw_prod[WIN_FRAC_MSB:gtz_pkg::WIN_FRAC_BITS];
                    prod_reg <= coeff_sel * q1_reg[0];
                    tk_reg   <= 2'd0;
                end
                gtz_pkg::ST_ACC: begin
                    prod_reg  <= coeff_nxt * q1_reg[1];
                    q1_reg[0] <= q1_reg[1];
                    q1_reg[1] <= q1_reg[2];
                    q1_reg[2] <= q0_sat;
                    q2_reg[0] <= q2_reg[1];
                    q2_reg[1] <= q2_reg[2];
                    q2_reg[2] <= q1_reg[0];
                    if (tk_reg == 2'd2) begin
                        tk_reg    <= 2'd0;
                        count_reg <= count_reg + LW'(1);
                    end else begin
                        tk_reg    <= tk_reg + 2'd1;
                    end
                end
                gtz_pkg::ST_FDIV: begin
                    den_reg     <= DW'(scale_reg * span);
                    zero_reg    <= zero_now;
                    tk_reg      <= 2'd0;
                    mag_work[0] <= '0;
                    mag_work[1] <= '0;
                    mag_work[2] <= '0;
                end
                gtz_pkg::ST_FC: begin
                    prod_reg <= q1_reg[0] * cos_sel;
                end
                gtz_pkg::ST_FS: begin
                    num_re_reg <= abs49(re_val);
                    prod_reg   <= q1_reg[0] * sin_sel;
                end
                gtz_pkg::ST_FI: begin
                    num_im_reg <= abs49(im_val);
                end
                gtz_pkg::ST_DRE: begin
                    if (div_done) begin
                        qa_reg <= div_quot;
                    end
                end
                gtz_pkg::ST_DIM: begin
                    if (div_done) begin
                        qb_reg <= div_quot;
                    end
                end
                gtz_pkg::ST_SQ: begin
                    sa_reg  <= qa_reg[15:0] * qa_reg[15:0];
                    sb_reg  <= qb_reg[15:0] * qb_reg[15:0];
                    sat_reg <= (|qa_reg[NW-1:16]) || (|qb_reg[NW-1:16]);
                end
                gtz_pkg::ST_SUM: begin
                    mag_work[tk_reg] <= (sat_reg || sum33[32]) ? 32'hFFFF_FFFF : sum33[31:0];
                    q1_reg[0] <= q1_reg[1];
                    q1_reg[1] <= q1_reg[2];
                    q1_reg[2] <= q1_reg[0];
                    q2_reg[0] <= q2_reg[1];
                    q2_reg[1] <= q2_reg[2];
                    q2_reg[2] <= q2_reg[0];
                    tk_reg    <= tk_reg + 2'd1;
                end
                gtz_pkg::ST_OUT: begin
                    if (out_load) begin
                        count_reg <= '0;
                        min_reg   <= '0;
                        max_reg   <= '0;
                        q1_reg[0] <= '0;
                        q1_reg[1] <= '0;
                        q1_reg[2] <= '0;
                        q2_reg[0] <= '0;
                        q2_reg[1] <= '0;
                        q2_reg[2] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mag_reg[0] <= mag_work[0];
            out_mag_reg[1] <= mag_work[1];
            out_mag_reg[2] <= mag_work[2];
            out_zero_reg   <= zero_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_mag_one   = out_mag_reg[0];
    assign m_mag_two   = out_mag_reg[1];
    assign m_mag_three = out_mag_reg[2];
    assign m_zero_span = out_zero_reg;

    // ---------------- assertions ----------------
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pop |-> (state_reg == gtz_pkg::ST_IDLE))
        else $error("queue popped outside idle");

    a_zero_mags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_span) |->
            (m_mag_one == 32'd0 && m_mag_two == 32'd0 && m_mag_three == 32'd0))
        else $error("zero span result with nonzero magnitude");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gtz_pkg::ST_OUT && out_valid_reg && !m_ready)
            |=> (state_reg == gtz_pkg::ST_OUT))
        else $error("pending result overwritten");

endmodule

// ===== sv/three_tone_goertzel_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_tone_goertzel_detector_top
// Windowed three-tone Goertzel detector with a decoupled input queue.
// ----------------------------------------------------------------------------
// A window write goes into the table as the engine pops it; a sample passes
// through the queue pop with the window memory read, the weighting multiply,
// and one accumulate step per tone on the shared coefficient multiplier. At
// the end of a block the engine runs the one-bit-per-cycle divider twice per
// tone, or skips the division when the span or the scale is zero, and may then
// wait for the result register to empty. A two-entry queue takes input while
// the engine works, and the result register holds one finished result while
// the next block is processed. The window table has no reset; only written
// entries may be read.
module three_tone_goertzel_detector_top #(
    parameter int WINDOW_DEPTH    = gtz_pkg::WINDOW_DEPTH_DEF,
    parameter int COEFF_FRAC_BITS = gtz_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gtz_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtz_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic signed [15:0]             s_sample,
    input  logic [8:0]                     s_window_index,
    input  logic signed [15:0]             s_window_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_mag_one,
    output logic [31:0]                    m_mag_two,
    output logic [31:0]                    m_mag_three,
    output logic                           m_zero_span
);

    logic               item_valid;
    logic               item_pop;
    gtz_pkg::gtz_item_t item;

    gtz_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_sample       (s_sample),
        .s_window_index (s_window_index),
        .s_window_value (s_window_value),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    gtz_back #(
        .WINDOW_DEPTH    (WINDOW_DEPTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_mag_one   (m_mag_one),
        .m_mag_two   (m_mag_two),
        .m_mag_three (m_mag_three),
        .m_zero_span (m_zero_span)
    );

endmodule
